[sv/rcpm_pkg.sv]
// ----------------------------------------------------------------------------
// rcpm_pkg
// Shared types and constants of the RC pulse capture and median block.
// ----------------------------------------------------------------------------
package rcpm_pkg;

   // Block size
   localparam int NUM_CHANNELS = 6;
   localparam int WINDOW_LEN   = 5;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int PERIOD_W = 17;
   localparam int LIMIT_W  = 8;
   localparam int CHAN_W   = 3;
   localparam int MUX_W    = 3;

   // Derived index widths
   localparam int ROW_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int STEP_W = $clog2(NUM_CHANNELS + 1);
   localparam int RANK_W = $clog2(WINDOW_LEN + 1);

   // Register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [PERIOD_W-1:0] TIMER_PERIOD_RESET     = PERIOD_W'(40000);
   localparam logic [LIMIT_W-1:0]  DISCONNECT_LIMIT_RESET = LIMIT_W'(5);

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [PERIOD_W-1:0] period_type;
   typedef logic [LIMIT_W-1:0]  limit_type;

   typedef enum logic [1:0] {
      CMD_CAPTURE = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   typedef enum logic {
      REG_TIMER_PERIOD     = 1'b0,
      REG_DISCONNECT_LIMIT = 1'b1
   } reg_index_type;

   // Capture side status, next-state values after the current item
   typedef struct packed {
      logic [MUX_W-1:0] mux_select;
      logic             falling_edge;
      logic             frame_done;
   } cap_status_type;

endpackage

[sv/rcpm_csr.sv]
// ----------------------------------------------------------------------------
// rcpm_csr
// Configuration registers: timer period and disconnect limit on an APB port.
// ----------------------------------------------------------------------------
module rcpm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [rcpm_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rcpm_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rcpm_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output rcpm_pkg::period_type              timer_period,
   output rcpm_pkg::limit_type               disconnect_limit
);
   import rcpm_pkg::*;

   period_type    period_ff;
   limit_type     limit_ff;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index  = reg_index_type'(paddr[2]);
   assign wr_en  = psel & penable & pwrite & pready;

   // Write on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= TIMER_PERIOD_RESET;
         limit_ff  <= DISCONNECT_LIMIT_RESET;
      end else if (wr_en) begin
         unique case (index)
            REG_TIMER_PERIOD:     period_ff <= pwdata[PERIOD_W-1:0];
            REG_DISCONNECT_LIMIT: limit_ff  <= pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (index)
         REG_TIMER_PERIOD:     prdata = CSR_DATA_W'(period_ff);
         REG_DISCONNECT_LIMIT: prdata = CSR_DATA_W'(limit_ff);
         default:              prdata = '0;
      endcase
   end

   assign timer_period     = period_ff;
   assign disconnect_limit = limit_ff;

endmodule

[sv/rcpm_capture.sv]
// ----------------------------------------------------------------------------
// rcpm_capture
// Edge stamp store, multiplexer sequencing and pulse width calculation.
// ----------------------------------------------------------------------------
module rcpm_capture (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    capture_en,
   input  rcpm_pkg::sample_type    capture_count,
   input  rcpm_pkg::period_type    timer_period,
   output rcpm_pkg::cap_status_type status,
   output rcpm_pkg::sample_type    widths [rcpm_pkg::NUM_CHANNELS]
);
   import rcpm_pkg::*;

   // Width between two stamps, unwrapped over the timer period and clamped
   function automatic sample_type pulse_width(input period_type period,
                                              input sample_type a,
                                              input sample_type b);
      logic signed [PERIOD_W+1:0] w;
      sample_type                 res;
      w = '0;
      if (b >= a) begin
         res = b - a;
      end else begin
         w = $signed({2'b00, period}) - $signed({3'b000, a}) + $signed({3'b000, b});
         if (w < 0) begin
            res = '0;
         end else if (w > $signed((PERIOD_W+2)'(2**SAMPLE_W - 1))) begin
            res = '1;
         end else begin
            res = w[SAMPLE_W-1:0];
         end
      end
      return res;
   endfunction

   logic [STEP_W-1:0] step_ff, step_in;
   logic [MUX_W-1:0]  mux_ff, mux_in;
   logic              edge_ff, edge_in;
   logic              done;
   sample_type        stamps_ff [NUM_CHANNELS];
   sample_type        widths_ff [NUM_CHANNELS];
   sample_type        ends      [NUM_CHANNELS+1];
   sample_type        width_calc [NUM_CHANNELS];

   // Step the multiplexer and pick the polarity for the next edge
   always_comb begin
      step_in = step_ff;
      mux_in  = mux_ff;
      edge_in = edge_ff;
      done    = 1'b0;
      if (capture_en) begin
         edge_in = (step_ff == STEP_W'(NUM_CHANNELS - 1));
         if (step_ff < STEP_W'(NUM_CHANNELS)) begin
            step_in = step_ff + 1'b1;
            if (step_in != STEP_W'(NUM_CHANNELS)) begin
               mux_in = MUX_W'(step_in);
            end
         end else begin
            step_in = '0;
            mux_in  = '0;
            done    = 1'b1;
         end
      end
   end

   // Widths from neighbouring stamps, the last stamp taken straight from the input
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         ends[c] = stamps_ff[c];
      end
      ends[NUM_CHANNELS] = capture_count;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         width_calc[c] = pulse_width(timer_period, ends[c], ends[c+1]);
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         mux_ff  <= '0;
         edge_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         mux_ff  <= mux_in;
         edge_ff <= edge_in;
      end
   end

   // Hold the stamps of the frame in progress
   always_ff @(posedge clock) begin
      if (capture_en && (step_ff < STEP_W'(NUM_CHANNELS))) begin
         stamps_ff[step_ff[ROW_W-1:0]] <= capture_count;
      end
   end

   // Latch the widths of a completed frame
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            widths_ff[c] <= '0;
         end
      end else if (done) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            widths_ff[c] <= width_calc[c];
         end
      end
   end

   assign status.mux_select   = mux_in;
   assign status.falling_edge = edge_in;
   assign status.frame_done   = done;
   assign widths              = widths_ff;

   // Checks
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_W'(NUM_CHANNELS))
      else $error("capture step beyond the last stamp");
   a_falling_last: assert property (@(posedge clock) disable iff (reset)
      edge_ff |-> step_ff == STEP_W'(NUM_CHANNELS))
      else $error("falling edge selected away from the last stamp");
   a_done_wraps: assert property (@(posedge clock) disable iff (reset)
      done |=> step_ff == '0 && mux_ff == '0 && !edge_ff)
      else $error("frame completion did not restart the sequence");

endmodule

[sv/rcpm_window.sv]
// ----------------------------------------------------------------------------
// rcpm_window
// Per-channel sample windows and the median of the selected channel.
// ----------------------------------------------------------------------------
module rcpm_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tick_en,
   input  rcpm_pkg::sample_type    widths [rcpm_pkg::NUM_CHANNELS],
   input  logic [rcpm_pkg::CHAN_W-1:0] channel,
   output rcpm_pkg::sample_type    median
);
   import rcpm_pkg::*;

   localparam logic [RANK_W-1:0] RANK = RANK_W'(WINDOW_LEN / 2);

   // Element of sorted rank RANK, first match wins
   function automatic sample_type window_median(input sample_type win [WINDOW_LEN]);
      sample_type        med;
      logic              found;
      logic [RANK_W-1:0] less;
      logic [RANK_W-1:0] lesseq;
      med   = '0;
      found = 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         less   = '0;
         lesseq = '0;
         for (int j = 0; j < WINDOW_LEN; j++) begin
            if (win[j] < win[i]) less = less + 1'b1;
            if (win[j] <= win[i]) lesseq = lesseq + 1'b1;
         end
         if (!found && (less <= RANK) && (RANK < lesseq)) begin
            med   = win[i];
            found = 1'b1;
         end
      end
      return med;
   endfunction

   sample_type       windows_ff [NUM_CHANNELS][WINDOW_LEN];
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ch_ok;
   logic [ROW_W-1:0] row_idx;
   sample_type       row [WINDOW_LEN];

   // Advance the write position, wrapping at the window length
   assign pos_in = (pos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
               windows_ff[c][k] <= '0;
            end
         end
      end else if (tick_en) begin
         pos_ff <= pos_in;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            windows_ff[c][pos_ff] <= widths[c];
         end
      end
   end

   // Select the channel row, out-of-range channels read as zero
   assign ch_ok   = {1'b0, channel} < (CHAN_W+1)'(NUM_CHANNELS);
   assign row_idx = ch_ok ? channel[ROW_W-1:0] : '0;
   assign row     = windows_ff[row_idx];
   assign median  = ch_ok ? window_median(row) : '0;

   // Checks
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(WINDOW_LEN))
      else $error("window position beyond window length");
   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !tick_en |=> $stable(pos_ff))
      else $error("window position moved without a tick");
   a_bad_channel: assert property (@(posedge clock) disable iff (reset)
      !ch_ok |-> median == '0)
      else $error("median reported for an absent channel");

endmodule

[sv/rc_pulse_capture_median.sv]
// Path: an accepted request transfer goes into the input stage register, and
//   its response into the response register once that is free or drains.
// Throughput: one transfer per cycle; the item stage and the response register
//   each advance whenever the response side takes or has room.
// Reset: synchronous; clears the sequencer, widths, sample windows and counters
//   at once and loads period 40000 and disconnect limit 5; no clearing pass.
// ----------------------------------------------------------------------------
// rc_pulse_capture_median
// Multiplexed RC pulse-width capture with a running median per channel.
// ----------------------------------------------------------------------------
module rc_pulse_capture_median (
   input  logic        clock,
   input  logic        reset,
   // Request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] capture_count, [18:16] channel
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   // Response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] mux_select, [3] falling_edge,
                                    // [19:4] median_value, [20] connected
   output logic        rsp_tlast,   // frame_done
   // Register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rcpm_pkg::*;

   period_type       timer_period;
   limit_type        disconnect_limit;

   // Item stage
   logic             stage_valid_ff;
   cmd_type          stage_cmd_ff;
   sample_type       stage_count_ff;
   logic [CHAN_W-1:0] stage_chan_ff;
   logic             stage_adv;

   // Decoded strobes
   logic             capture_en;
   logic             tick_en;
   logic             read_en;

   cap_status_type   cap_status;
   sample_type       widths [NUM_CHANNELS];
   sample_type       win_median;

   // Missed-update counter
   limit_type        missed_ff, missed_in;
   logic [LIMIT_W:0] missed_inc;
   logic             connected_now;
   logic             connected_next;

   // Response register
   logic             rsp_valid_ff;
   logic [MUX_W-1:0] rsp_mux_ff;
   logic             rsp_edge_ff;
   logic             rsp_done_ff;
   sample_type       rsp_median_ff;
   logic             rsp_conn_ff;

   rcpm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (csr_psel),
      .penable          (csr_penable),
      .pwrite           (csr_pwrite),
      .paddr            (csr_paddr),
      .pwdata           (csr_pwdata),
      .prdata           (csr_prdata),
      .pready           (csr_pready),
      .timer_period     (timer_period),
      .disconnect_limit (disconnect_limit)
   );

   // Handshake: stage moves on when the response register is free or drains
   assign stage_adv  = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_cmd_ff   <= cmd_type'(req_tuser);
         stage_count_ff <= req_tdata[SAMPLE_W-1:0];
         stage_chan_ff  <= req_tdata[SAMPLE_W+CHAN_W-1:SAMPLE_W];
      end
   end

   // Decode the command of the staged item
   always_comb begin
      capture_en = 1'b0;
      tick_en    = 1'b0;
      read_en    = 1'b0;
      unique case (stage_cmd_ff)
         CMD_CAPTURE: capture_en = stage_adv;
         CMD_TICK:    tick_en    = stage_adv;
         CMD_READ:    read_en    = stage_adv;
         default: ;
      endcase
   end

   rcpm_capture u_capture (
      .clock         (clock),
      .reset         (reset),
      .capture_en    (capture_en),
      .capture_count (stage_count_ff),
      .timer_period  (timer_period),
      .status        (cap_status),
      .widths        (widths)
   );

   rcpm_window u_window (
      .clock   (clock),
      .reset   (reset),
      .tick_en (tick_en),
      .widths  (widths),
      .channel (stage_chan_ff),
      .median  (win_median)
   );

   // Count missed updates, saturating at the limit; a full frame clears it
   assign missed_inc = {1'b0, missed_ff} + 1'b1;

   always_comb begin
      missed_in = missed_ff;
      if (cap_status.frame_done) begin
         missed_in = '0;
      end else if (tick_en) begin
         missed_in = (missed_inc >= {1'b0, disconnect_limit}) ?
                     disconnect_limit : missed_inc[LIMIT_W-1:0];
      end
   end

   assign connected_now  = missed_ff < disconnect_limit;
   assign connected_next = missed_in < disconnect_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         missed_ff <= '0;
      end else begin
         missed_ff <= missed_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv) begin
         rsp_mux_ff    <= cap_status.mux_select;
         rsp_edge_ff   <= cap_status.falling_edge;
         rsp_done_ff   <= cap_status.frame_done;
         rsp_median_ff <= (read_en && connected_now) ? win_median : '0;
         rsp_conn_ff   <= connected_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tdata  = {3'b000, rsp_conn_ff, rsp_median_ff, rsp_edge_ff, rsp_mux_ff};

   // Checks
   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_done_ff |-> rsp_mux_ff == '0 && !rsp_edge_ff)
      else $error("completed frame not reported on the first channel");
   a_median_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_median_ff != '0 |-> rsp_conn_ff)
      else $error("median reported while disconnected");
   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      cap_status.frame_done |=> missed_ff == '0)
      else $error("missed-update counter not cleared by a frame");
   a_adv_loads: assert property (@(posedge clock) disable iff (reset)
      stage_adv |=> rsp_valid_ff)
      else $error("staged item lost before the response register");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RC pulse capture and running median block.
// Drives capture, tick, read and unused commands over the request stream and
// sets the period and disconnect limit over the register port. A request-level
// predictor in the bench works out the status for every request, and each
// response transfer is checked against the oldest outstanding status.
// ----------------------------------------------------------------------------
module tb;
   import rcpm_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         MAX_REPORTS = 10;

   typedef struct packed {
      logic [MUX_W-1:0] mux_select;
      logic             falling_edge;
      logic             frame_done;
      sample_type       median_value;
      logic             connected;
   } rc_status_type;

   // DUT ports
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [15:0] capture_count, [18:16] channel
   logic [1:0]  req_tuser = '0;   // [1:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [2:0] mux_select, [3] falling_edge,
                                  // [19:4] median_value, [20] connected
   logic        rsp_tlast;        // frame_done
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Predictor state and configuration
   int          cfg_period = 40000;
   int          cfg_limit = 5;
   int          seq_step = 0;
   logic [2:0]  mux_sel = '0;
   logic        pol_falling = 1'b0;
   sample_type  stamp_mem [NUM_CHANNELS+1];
   sample_type  frame_widths [NUM_CHANNELS];
   sample_type  windows [NUM_CHANNELS][WINDOW_LEN];
   int          win_wr_pos = 0;
   int          miss_count = 0;

   // Bench bookkeeping
   rc_status_type status_due_q [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          req_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          items_sent = 0;

   rc_pulse_capture_median dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort a run that exceeds the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rc_pulse_capture_median verification failed");
         $finish;
      end
   end

   // Stall the response side at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic sample_type width_between(sample_type a, sample_type b);
      int w;
      if (b >= a)
         w = int'(b) - int'(a);
      else
         w = cfg_period - int'(a) + int'(b);
      if (w < 0)
         w = 0;
      if (w > 65535)
         w = 65535;
      return sample_type'(w);
   endfunction

   function automatic sample_type window_median(int row);
      sample_type s [WINDOW_LEN];
      sample_type t;
      int j;
      for (int i = 0; i < WINDOW_LEN; i++)
         s[i] = windows[row][i];
      // insertion sort, then take the middle rank
      for (int i = 1; i < WINDOW_LEN; i++) begin
         t = s[i];
         j = i - 1;
         while (j >= 0 && s[j] > t) begin
            s[j+1] = s[j];
            j--;
         end
         s[j+1] = t;
      end
      return s[WINDOW_LEN/2];
   endfunction

   function automatic rc_status_type rc_status_after(logic [1:0] cmd, sample_type count,
                                                     logic [2:0] chan);
      rc_status_type r;
      int next_miss;
      r = '0;
      case (cmd)
         CMD_CAPTURE: begin
            if (seq_step > NUM_CHANNELS)
               seq_step = 0;
            stamp_mem[seq_step] = count;
            pol_falling = (seq_step == NUM_CHANNELS - 1);
            if (seq_step < NUM_CHANNELS) begin
               seq_step++;
               if (seq_step != NUM_CHANNELS)
                  mux_sel = 3'(seq_step);
            end else begin
               // frame complete: latch widths and clear the miss counter
               seq_step = 0;
               mux_sel = '0;
               for (int i = 0; i < NUM_CHANNELS; i++)
                  frame_widths[i] = width_between(stamp_mem[i], stamp_mem[i+1]);
               miss_count = 0;
               r.frame_done = 1'b1;
            end
         end
         CMD_TICK: begin
            next_miss = miss_count + 1;
            miss_count = (next_miss >= cfg_limit) ? cfg_limit : next_miss;
            if (win_wr_pos >= WINDOW_LEN)
               win_wr_pos = 0;
            for (int i = 0; i < NUM_CHANNELS; i++)
               windows[i][win_wr_pos] = frame_widths[i];
            win_wr_pos++;
            if (win_wr_pos >= WINDOW_LEN)
               win_wr_pos = 0;
         end
         CMD_READ: begin
            if (int'(chan) < NUM_CHANNELS && miss_count < cfg_limit)
               r.median_value = window_median(int'(chan));
         end
         default: ;
      endcase
      r.mux_select   = mux_sel;
      r.falling_edge = pol_falling;
      r.connected    = (miss_count < cfg_limit);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rc_status_type got;
      rc_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.mux_select   = rsp_tdata[2:0];
         got.falling_edge = rsp_tdata[3];
         got.frame_done   = rsp_tlast;
         got.median_value = rsp_tdata[19:4];
         got.connected    = rsp_tdata[20];
         if (status_due_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response transfer with nothing outstanding: %h",
                        $realtime, got);
         end else begin
            want = status_due_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: status mismatch (expected/actual): mux %0d/%0d falling %0b/%0b",
                           $realtime, want.mux_select, got.mux_select,
                           want.falling_edge, got.falling_edge);
                  $display("   done %0b/%0b median %0d/%0d connected %0b/%0b",
                           want.frame_done, got.frame_done,
                           want.median_value, got.median_value,
                           want.connected, got.connected);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared drivers
   // ---------------------------------------------------------------------
   // Send one request; valid stays high afterwards until the next task drives it
   task automatic push_req(logic [1:0] cmd, sample_type count, logic [2:0] chan);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, chan, count};
      do
         @(posedge clock);
      while (!req_tready);
      status_due_q.push_back(rc_status_after(cmd, count, chan));
      items_sent++;
   endtask

   // Hold the request side until every outstanding status has come back
   task automatic drain_rsp();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_due_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_TIMER_PERIOD)
         cfg_period = int'(value[PERIOD_W-1:0]);
      else
         cfg_limit = int'(value[LIMIT_W-1:0]);
   endtask

   // Frame from wherever the sequencer stands, stamps kept in period but for an occasional random one
   task automatic send_frame();
      int n;
      int stamp;
      n = NUM_CHANNELS + 1 - seq_step;
      if (n <= 0)
         n = NUM_CHANNELS + 1;
      stamp = (cfg_period > 1) ? $urandom_range(cfg_period - 1) : 0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(19) == 0)
            push_req(CMD_CAPTURE, sample_type'($urandom), 3'($urandom));
         else
            push_req(CMD_CAPTURE, sample_type'(stamp), 3'($urandom));
         stamp = (stamp + $urandom_range(800, 2200)) % cfg_period;
      end
   endtask

   // Mixed traffic: mostly frames followed by ticks and reads, some noise
   task automatic run_traffic(int n_items);
      int stop_at;
      int pick;
      int n_ticks;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            send_frame();
            n_ticks = $urandom_range(1, 6);
            for (int t = 0; t < n_ticks; t++) begin
               push_req(CMD_TICK, sample_type'($urandom), 3'($urandom));
               repeat ($urandom_range(0, 2))
                  push_req(CMD_READ, sample_type'($urandom), 3'($urandom_range(7)));
            end
         end else if (pick < 97) begin
            repeat ($urandom_range(1, 4))
               push_req(2'($urandom), sample_type'($urandom), 3'($urandom));
         end else begin
            drain_rsp();
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Status straight after reset, bad channel and the unused command
   task automatic test_reset_state();
      push_req(CMD_READ, 16'h0000, 3'd0);
      push_req(CMD_READ, 16'hFFFF, 3'd7);
      push_req(CMD_UNUSED, 16'hFFFF, 3'd7);
      push_req(CMD_TICK, 16'h0000, 3'd0);
      push_req(CMD_READ, 16'h0000, 3'd5);
      drain_rsp();
   endtask

   // One frame with extreme stamps, then ticks until disconnected
   task automatic test_directed_frame();
      sample_type stamps [NUM_CHANNELS+1];
      stamps = '{16'd0, 16'd1500, 16'd3000, 16'hFFFF, 16'd100, 16'd39999, 16'd0};
      foreach (stamps[i])
         push_req(CMD_CAPTURE, stamps[i], 3'(i));
      repeat (3)
         push_req(CMD_TICK, 16'h0000, 3'd0);
      for (int c = 0; c < 8; c++)
         push_req(CMD_READ, 16'h0000, 3'(c));
      repeat (2)
         push_req(CMD_TICK, 16'hFFFF, 3'd7);
      push_req(CMD_READ, 16'h0000, 3'd2);
      drain_rsp();
   endtask

   // Register extremes, each with a short burst of traffic
   task automatic test_register_extremes();
      csr_write(REG_TIMER_PERIOD, 32'd65536);
      csr_write(REG_DISCONNECT_LIMIT, 32'd255);
      // wrap across the top of the largest period
      push_req(CMD_CAPTURE, 16'd65000, 3'd0);
      push_req(CMD_CAPTURE, 16'd100, 3'd0);
      push_req(CMD_CAPTURE, 16'd50, 3'd0);
      repeat (4)
         push_req(CMD_CAPTURE, 16'd60, 3'd0);
      repeat (5)
         push_req(CMD_TICK, 16'd0, 3'd0);
      push_req(CMD_READ, 16'd0, 3'd1);
      run_traffic(30);
      drain_rsp();

      csr_write(REG_TIMER_PERIOD, 32'd1);
      csr_write(REG_DISCONNECT_LIMIT, 32'd1);
      run_traffic(30);
      drain_rsp();

      // a zero limit reports disconnected throughout
      csr_write(REG_DISCONNECT_LIMIT, 32'd0);
      push_req(CMD_TICK, 16'd0, 3'd0);
      push_req(CMD_READ, 16'd0, 3'd0);
      send_frame();
      push_req(CMD_READ, 16'd0, 3'd3);
      run_traffic(20);
      drain_rsp();
   endtask

   task automatic test_random_phase(int idle_pct, int stall_pct, int period, int limit,
                                    int n_items);
      csr_write(REG_TIMER_PERIOD, 32'(period));
      csr_write(REG_DISCONNECT_LIMIT, 32'(limit));
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      run_traffic(n_items);
      drain_rsp();
   endtask

   initial begin
      repeat (5)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_directed_frame();
      test_register_extremes();
      test_random_phase(0, 0, 40000, 5, 210);
      test_random_phase(83, 0, 20000, 3, 210);
      test_random_phase(0, 83, 65536, 8, 210);
      test_random_phase(32, 32, 1000, 2, 210);

      repeat (10)
         @(posedge clock);
      if (mismatch_count == 0 && status_due_q.size() == 0)
         $display("rc_pulse_capture_median verification clean");
      else
         $display("rc_pulse_capture_median verification failed");
      $finish;
   end

endmodule

[sim.f]
sv/rcpm_pkg.sv
sv/rcpm_csr.sv
sv/rcpm_capture.sv
sv/rcpm_window.sv
sv/rc_pulse_capture_median.sv
test/tb.sv
